### hdl/nrb_pkg.sv
package nrb_pkg;

  // fixed widths of the channel fields
  localparam int IN_KEY_BITS   = 16;
  localparam int OUT_IDX_BITS  = 4;

  // default sizing of the binding table
  localparam int DEF_NUM_ENTRIES = 16;
  localparam int DEF_KEY_BITS    = 16;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic start;
    logic rd_en;
    logic done;
    logic idle;
  } ctrl_t;

  // store write controls
  typedef struct packed {
    logic claim;
    logic release_entry;
  } store_cmd_t;

endpackage

### hdl/nrb_req_if.sv
interface nrb_req_if;
  import nrb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [IN_KEY_BITS-1:0] name_key;
  logic                   is_temporary;

  modport source (output valid, output name_key, output is_temporary, input ready);
  modport sink   (input valid, input name_key, input is_temporary, output ready);

endinterface

### hdl/nrb_rsp_if.sv
interface nrb_rsp_if;
  import nrb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OUT_IDX_BITS-1:0] register_index;
  logic                    was_hit;
  logic                    was_released;
  logic                    pool_full;

  modport source (output valid, output register_index, output was_hit,
                  output was_released, output pool_full, input ready);
  modport sink   (input valid, input register_index, input was_hit,
                  input was_released, input pool_full, output ready);

endinterface

### hdl/nrb_store.sv
module nrb_store #(
  parameter int NUM_ENTRIES = nrb_pkg::DEF_NUM_ENTRIES,
  parameter int KEY_BITS    = nrb_pkg::DEF_KEY_BITS,
  localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output logic [KEY_BITS-1:0] rd_key,
  output logic                rd_occ,
  input  nrb_pkg::store_cmd_t cmd,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [KEY_BITS-1:0] wr_key
);
  import nrb_pkg::*;

  logic [KEY_BITS-1:0]    key_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] occ;

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      key_mem[wr_idx] <= wr_key;
    end
    if (rd_en) begin
      rd_key <= key_mem[rd_idx];
    end
  end

  // occupancy bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_occ <= 1'b0;
    end else begin
      if (cmd.claim) begin
        occ[wr_idx] <= 1'b1;
      end else if (cmd.release_entry) begin
        occ[wr_idx] <= 1'b0;
      end
      if (rd_en) begin
        rd_occ <= occ[rd_idx];
      end
    end
  end

endmodule

### hdl/nrb_match.sv
module nrb_match #(
  parameter int NUM_ENTRIES = nrb_pkg::DEF_NUM_ENTRIES,
  parameter int KEY_BITS    = nrb_pkg::DEF_KEY_BITS,
  localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  nrb_pkg::ctrl_t                  ctrl,
  input  logic [IDX_W-1:0]                rd_idx,
  input  logic [nrb_pkg::IN_KEY_BITS-1:0] in_key,
  input  logic                            in_temp,
  input  logic [KEY_BITS-1:0]             rd_key,
  input  logic                            rd_occ,
  output logic [KEY_BITS-1:0]             key,
  output logic                            temp,
  output logic                            found,
  output logic [IDX_W-1:0]                found_idx,
  output logic                            free_found,
  output logic [IDX_W-1:0]                free_idx
);
  import nrb_pkg::*;

  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_now;
  logic             free_now;

  // shared comparator on the entry read last cycle
  assign hit_now  = cmp_valid && !found && rd_occ && (rd_key == key);
  assign free_now = cmp_valid && !free_found && !rd_occ;

  // request latch and compare pipeline tag
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      key  <= KEY_BITS'(in_key);
      temp <= in_temp;
    end
    cmp_idx <= rd_idx;
  end

  // first match and first free entry seen during the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid  <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      cmp_valid <= ctrl.rd_en;
      if (ctrl.start) begin
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (hit_now) begin
          found     <= 1'b1;
          found_idx <= cmp_idx;
        end
        if (free_now) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

endmodule

### hdl/nrb_ctrl.sv
module nrb_ctrl #(
  parameter int NUM_ENTRIES = nrb_pkg::DEF_NUM_ENTRIES,
  localparam int IDX_W      = $clog2(NUM_ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             found,
  output nrb_pkg::ctrl_t   ctrl,
  output logic [IDX_W-1:0] rd_idx
);
  import nrb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (found) state_next = S_FINISH;
        else if (rd_idx == LAST_IDX) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE: begin
        ctrl.idle  = 1'b1;
        ctrl.start = accept;
      end
      S_SCAN:   ctrl.rd_en = !found;
      S_DRAIN:  ctrl.rd_en = 1'b0;
      S_FINISH: ctrl.done  = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  // state and scan address
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_idx <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) begin
        rd_idx <= '0;
      end else if (ctrl.rd_en && rd_idx != LAST_IDX) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

endmodule

### hdl/name_to_register_binding_table.sv
// Name to register binding table.
// A request on req carries name_key and is_temporary. The block searches its
// table for an occupied entry holding the key; on a hit it returns that
// entry's index with was_hit set, and a temporary also frees the entry
// (was_released). Without a hit the lowest free entry is claimed and its
// index returned; with no free entry pool_full is set and nothing changes.
// One result item on rsp follows each request item.
// Timing: the entries are read one per cycle from the key memory and checked
// by a single comparator. The scan ends after the first hit and otherwise
// reads the whole table; one item is in flight at a time, and req is ready
// again once the block is idle and the result register is free.
// Reset (rst, synchronous) clears all occupancy bits at once; keys are not
// cleared and are only compared on occupied entries.
// A stalled receiver holds the result in the output register; no new item is
// taken until that result has gone.
module name_to_register_binding_table #(
  parameter int NUM_ENTRIES = nrb_pkg::DEF_NUM_ENTRIES,
  parameter int KEY_BITS    = nrb_pkg::DEF_KEY_BITS
) (
  input  logic         clk,
  input  logic         rst,
  nrb_req_if.sink      req,
  nrb_rsp_if.source    rsp
);
  import nrb_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);

  ctrl_t               ctrl;
  store_cmd_t          cmd;
  logic                accept;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [KEY_BITS-1:0] rd_key;
  logic                rd_occ;
  logic [KEY_BITS-1:0] key;
  logic                temp;
  logic                found;
  logic [IDX_W-1:0]    found_idx;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  // request handshake
  assign req.ready = ctrl.idle && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  nrb_ctrl #(.NUM_ENTRIES(NUM_ENTRIES)) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .found  (found),
    .ctrl   (ctrl),
    .rd_idx (rd_idx)
  );

  nrb_store #(.NUM_ENTRIES(NUM_ENTRIES), .KEY_BITS(KEY_BITS)) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (ctrl.rd_en),
    .rd_idx (rd_idx),
    .rd_key (rd_key),
    .rd_occ (rd_occ),
    .cmd    (cmd),
    .wr_idx (wr_idx),
    .wr_key (key)
  );

  nrb_match #(.NUM_ENTRIES(NUM_ENTRIES), .KEY_BITS(KEY_BITS)) u_match (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .rd_idx     (rd_idx),
    .in_key     (req.name_key),
    .in_temp    (req.is_temporary),
    .rd_key     (rd_key),
    .rd_occ     (rd_occ),
    .key        (key),
    .temp       (temp),
    .found      (found),
    .found_idx  (found_idx),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  // table update at the end of the scan
  assign cmd.claim         = ctrl.done && !found && free_found;
  assign cmd.release_entry = ctrl.done && found && temp;
  assign wr_idx            = found ? found_idx : free_idx;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ctrl.done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      rsp.register_index <= (found || free_found) ? OUT_IDX_BITS'(wr_idx) : '0;
      rsp.was_hit        <= found;
      rsp.was_released   <= found && temp;
      rsp.pool_full      <= !found && !free_found;
    end
  end

  // no request is taken while a scan is running
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    !ctrl.idle |-> !req.ready)
    else $error("request accepted during a scan");

  // finishing a scan always presents a result
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |=> rsp.valid)
    else $error("scan finished without a result");

  // a freed entry must have been a hit, and a full pool is never a hit
  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!rsp.was_released || rsp.was_hit) && !(rsp.pool_full && rsp.was_hit))
    else $error("inconsistent result flags");

  // an accepted item starts the scan next cycle
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> ctrl.rd_en)
    else $error("scan did not start after acceptance");

endmodule
